### rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/apsp_pkg.sv
`default_nettype none
package apsp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COST_WIDTH_DEF   = 16;
   localparam int DIST_WIDTH_DEF   = 24;

   localparam int VCOUNT_WIDTH = 7;
   localparam logic [VCOUNT_WIDTH-1:0] VCOUNT_RESET = 7'd64;
   localparam int VERTEX_WIDTH = 6;
   localparam int CMD_WIDTH    = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_SOLVE = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE2,
      ST_QUERY,
      ST_RESP,
      ST_ROW,
      ST_ROWW,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

### rtl/apsp_ram.sv
`default_nettype none
module apsp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic      [WIDTH-1:0]         rdata_a,
   input  wire logic                     re_b,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a_ff <= mem_ff[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule
`default_nettype wire

### rtl/apsp_engine.sv
`default_nettype none
module apsp_engine #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
   parameter int COST_WIDTH   = apsp_pkg::COST_WIDTH_DEF,
   parameter int DIST_WIDTH   = apsp_pkg::DIST_WIDTH_DEF,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int NW = VW + 1,
   localparam int AW = 2 * VW
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [NW-1:0]                        n_value,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [apsp_pkg::CMD_WIDTH-1:0]       req_command,
   input  wire logic [apsp_pkg::VERTEX_WIDTH-1:0]    req_from_vertex,
   input  wire logic [apsp_pkg::VERTEX_WIDTH-1:0]    req_to_vertex,
   input  wire logic [COST_WIDTH-1:0]                req_edge_cost,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [DIST_WIDTH-1:0]                rsp_distance,
   output logic                                      rsp_reachable,
   output logic                                      mem_we,
   output logic      [AW-1:0]                        mem_waddr,
   output logic      [DIST_WIDTH-1:0]                mem_wdata,
   output logic                                      mem_re_a,
   output logic      [AW-1:0]                        mem_raddr_a,
   input  wire logic [DIST_WIDTH-1:0]                mem_rdata_a,
   output logic                                      mem_re_b,
   output logic      [AW-1:0]                        mem_raddr_b,
   input  wire logic [DIST_WIDTH-1:0]                mem_rdata_b
);

   localparam int EW = ((COST_WIDTH > DIST_WIDTH) ? COST_WIDTH : DIST_WIDTH) + 1;
   localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;
   localparam logic [VW-1:0] LAST_INDEX = VW'(MAX_VERTICES - 1);

   apsp_pkg::state_type state_ff, state_in;

   logic [VW-1:0]         clr_r_ff, clr_r_in;
   logic [VW-1:0]         clr_c_ff, clr_c_in;
   logic                  clr_resp_ff, clr_resp_in;
   logic [VW-1:0]         via_ff, via_in;
   logic [VW-1:0]         src_ff, src_in;
   logic [VW-1:0]         dst_ff, dst_in;
   logic                  pipe_valid_ff, pipe_valid_in;
   logic [VW-1:0]         pipe_dst_ff, pipe_dst_in;
   logic [DIST_WIDTH-1:0] src_via_ff, src_via_in;
   logic [VW-1:0]         a_idx_ff, a_idx_in;
   logic [VW-1:0]         b_idx_ff, b_idx_in;
   logic [DIST_WIDTH-1:0] cost_ff, cost_in;
   logic                  q_inr_ff, q_inr_in;
   logic [NW-1:0]         n_ff, n_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_WIDTH-1:0] rsp_distance_ff, rsp_distance_in;
   logic                  rsp_reachable_ff, rsp_reachable_in;

   apsp_pkg::cmd_type     cmd;
   logic                  in_range;
   logic                  slot_free;
   logic                  clr_last;
   logic                  dst_last;
   logic                  src_last;
   logic                  via_last;
   logic [EW-1:0]         cost_ext;
   logic [DIST_WIDTH-1:0] cost_sat;
   logic [DIST_WIDTH:0]   sum;
   logic [DIST_WIDTH-1:0] alt;
   logic [DIST_WIDTH-1:0] query_dist;

   assign cmd       = apsp_pkg::cmd_type'(req_command);
   assign in_range  = (32'(req_from_vertex) < 32'(n_value)) &&
                      (32'(req_to_vertex) < 32'(n_value));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_r_ff == LAST_INDEX) && (clr_c_ff == LAST_INDEX);
   assign dst_last  = (NW'(dst_ff) == n_ff - NW'(1));
   assign src_last  = (NW'(src_ff) == n_ff - NW'(1));
   assign via_last  = (NW'(via_ff) == n_ff - NW'(1));

   assign cost_ext = EW'(req_edge_cost);
   assign cost_sat = (cost_ext > EW'(DIST_INF)) ? DIST_INF : DIST_WIDTH'(cost_ext);

   // Saturating relaxation: the via entry is held for a whole row.
   always_comb begin
      sum = (DIST_WIDTH + 1)'(src_via_ff) + (DIST_WIDTH + 1)'(mem_rdata_a);
      if (src_via_ff == DIST_INF || mem_rdata_a == DIST_INF ||
          sum >= (DIST_WIDTH + 1)'(DIST_INF)) begin
         alt = DIST_INF;
      end else begin
         alt = DIST_WIDTH'(sum);
      end
   end

   assign query_dist = q_inr_ff ? mem_rdata_a : DIST_INF;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apsp_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_resp_ff ? apsp_pkg::ST_RESP : apsp_pkg::ST_IDLE;
            end
         end
         apsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (cmd)
                  apsp_pkg::CMD_CLEAR: state_in = apsp_pkg::ST_CLEAR;
                  apsp_pkg::CMD_EDGE:
                     state_in = in_range ? apsp_pkg::ST_EDGE2 : apsp_pkg::ST_RESP;
                  apsp_pkg::CMD_SOLVE:
                     state_in = (n_value != '0) ? apsp_pkg::ST_ROW : apsp_pkg::ST_RESP;
                  apsp_pkg::CMD_QUERY: state_in = apsp_pkg::ST_QUERY;
                  default: state_in = apsp_pkg::ST_IDLE;
               endcase
            end
         end
         apsp_pkg::ST_EDGE2: state_in = apsp_pkg::ST_RESP;
         apsp_pkg::ST_QUERY: begin
            if (slot_free) begin
               state_in = apsp_pkg::ST_IDLE;
            end
         end
         apsp_pkg::ST_RESP: begin
            if (slot_free) begin
               state_in = apsp_pkg::ST_IDLE;
            end
         end
         apsp_pkg::ST_ROW:  state_in = apsp_pkg::ST_ROWW;
         apsp_pkg::ST_ROWW: state_in = apsp_pkg::ST_SWEEP;
         apsp_pkg::ST_SWEEP: begin
            if (dst_last) begin
               state_in = apsp_pkg::ST_DRAIN;
            end
         end
         apsp_pkg::ST_DRAIN: begin
            state_in = (src_last && via_last) ? apsp_pkg::ST_RESP : apsp_pkg::ST_ROW;
         end
         default: state_in = apsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clr_r_in         = clr_r_ff;
      clr_c_in         = clr_c_ff;
      clr_resp_in      = clr_resp_ff;
      via_in           = via_ff;
      src_in           = src_ff;
      dst_in           = dst_ff;
      pipe_valid_in    = 1'b0;
      pipe_dst_in      = dst_ff;
      src_via_in       = src_via_ff;
      a_idx_in         = a_idx_ff;
      b_idx_in         = b_idx_ff;
      cost_in          = cost_ff;
      q_inr_in         = q_inr_ff;
      n_in             = n_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      req_ready        = 1'b0;

      // The write stage of the row sweep finishes in the cycle after its reads.
      mem_we      = pipe_valid_ff && (alt < mem_rdata_b);
      mem_waddr   = {src_ff, pipe_dst_ff};
      mem_wdata   = alt;
      mem_re_a    = 1'b0;
      mem_raddr_a = {via_ff, dst_ff};
      mem_re_b    = 1'b0;
      mem_raddr_b = {src_ff, dst_ff};

      case (state_ff)
         apsp_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = {clr_r_ff, clr_c_ff};
            mem_wdata = (clr_r_ff == clr_c_ff) ? '0 : DIST_INF;
            if (clr_c_ff == LAST_INDEX) begin
               clr_c_in = '0;
               clr_r_in = clr_last ? '0 : clr_r_ff + VW'(1);
            end else begin
               clr_c_in = clr_c_ff + VW'(1);
            end
         end
         apsp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            a_idx_in    = VW'(req_from_vertex);
            b_idx_in    = VW'(req_to_vertex);
            cost_in     = cost_sat;
            q_inr_in    = in_range;
            n_in        = n_value;
            via_in      = '0;
            src_in      = '0;
            clr_resp_in = 1'b1;
            if (req_valid && cmd == apsp_pkg::CMD_EDGE && in_range) begin
               mem_we    = 1'b1;
               mem_waddr = {VW'(req_from_vertex), VW'(req_to_vertex)};
               mem_wdata = cost_sat;
            end
            if (req_valid && cmd == apsp_pkg::CMD_QUERY) begin
               mem_re_a    = in_range;
               mem_raddr_a = {VW'(req_from_vertex), VW'(req_to_vertex)};
            end
         end
         apsp_pkg::ST_EDGE2: begin
            mem_we    = 1'b1;
            mem_waddr = {b_idx_ff, a_idx_ff};
            mem_wdata = cost_ff;
         end
         apsp_pkg::ST_QUERY: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_distance_in  = query_dist;
               rsp_reachable_in = (query_dist != DIST_INF);
            end
         end
         apsp_pkg::ST_RESP: begin
            clr_resp_in = 1'b0;
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_distance_in  = '0;
               rsp_reachable_in = 1'b0;
            end
         end
         apsp_pkg::ST_ROW: begin
            mem_re_a    = 1'b1;
            mem_raddr_a = {src_ff, via_ff};
         end
         apsp_pkg::ST_ROWW: begin
            src_via_in = mem_rdata_a;
            dst_in     = '0;
         end
         apsp_pkg::ST_SWEEP: begin
            mem_re_a      = 1'b1;
            mem_re_b      = 1'b1;
            pipe_valid_in = 1'b1;
            pipe_dst_in   = dst_ff;
            dst_in        = dst_ff + VW'(1);
         end
         apsp_pkg::ST_DRAIN: begin
            if (src_last) begin
               src_in = '0;
               via_in = via_ff + VW'(1);
            end else begin
               src_in = src_ff + VW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= apsp_pkg::ST_CLEAR;
         clr_r_ff      <= '0;
         clr_c_ff      <= '0;
         clr_resp_ff   <= 1'b0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         via_ff        <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         clr_r_ff      <= clr_r_in;
         clr_c_ff      <= clr_c_in;
         clr_resp_ff   <= clr_resp_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         via_ff        <= via_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         n_ff          <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_dst_ff      <= pipe_dst_in;
      src_via_ff       <= src_via_in;
      a_idx_ff         <= a_idx_in;
      b_idx_ff         <= b_idx_in;
      cost_ff          <= cost_in;
      q_inr_ff         <= q_inr_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_reachable = rsp_reachable_ff;

endmodule
`default_nettype wire

### rtl/all_pairs_shortest_path.sv
// Commands are handled one at a time: the next is taken only once the result of the last
// is issued to the output register. An add edge out of range writes nothing, and a solve
// with a vertex count of zero does no sweep.
// A finished word waits in the output register while the next command is taken.
// Synchronous reset sets vertex_count to 64 and starts a clearing pass over all
// MAX_VERTICES**2 entries (4096 by default) during which req_ready stays low.
`default_nettype none
`include "assert_macros.svh"
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
   parameter int COST_WIDTH   = apsp_pkg::COST_WIDTH_DEF,
   parameter int DIST_WIDTH   = apsp_pkg::DIST_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [apsp_pkg::VCOUNT_WIDTH-1:0]  csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [apsp_pkg::CMD_WIDTH-1:0]     req_command,
   input  wire logic [apsp_pkg::VERTEX_WIDTH-1:0]  req_from_vertex,
   input  wire logic [apsp_pkg::VERTEX_WIDTH-1:0]  req_to_vertex,
   input  wire logic [COST_WIDTH-1:0]              req_edge_cost,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [DIST_WIDTH-1:0]              rsp_distance,
   output logic                                    rsp_reachable,
   output logic                                    rsp_done_res
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int NW = VW + 1;
   localparam int AW = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

   logic [apsp_pkg::VCOUNT_WIDTH-1:0] vertex_count_ff, vertex_count_in;
   logic [31:0]           vc_ext;
   logic [NW-1:0]         n_value;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DIST_WIDTH-1:0] mem_wdata;
   logic                  mem_re_a;
   logic [AW-1:0]         mem_raddr_a;
   logic [DIST_WIDTH-1:0] mem_rdata_a;
   logic                  mem_re_b;
   logic [AW-1:0]         mem_raddr_b;
   logic [DIST_WIDTH-1:0] mem_rdata_b;

   assign csr_ready       = 1'b1;
   assign vertex_count_in = (csr_valid && csr_ready) ? csr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= apsp_pkg::VCOUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign vc_ext  = 32'(vertex_count_ff);
   assign n_value = (vc_ext > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_ext);

   apsp_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .COST_WIDTH   (COST_WIDTH),
      .DIST_WIDTH   (DIST_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .n_value         (n_value),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .req_edge_cost   (req_edge_cost),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance    (rsp_distance),
      .rsp_reachable   (rsp_reachable),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re_a        (mem_re_a),
      .mem_raddr_a     (mem_raddr_a),
      .mem_rdata_a     (mem_rdata_a),
      .mem_re_b        (mem_re_b),
      .mem_raddr_b     (mem_raddr_b),
      .mem_rdata_b     (mem_rdata_b)
   );

   apsp_ram #(
      .WIDTH (DIST_WIDTH),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re_a    (mem_re_a),
      .raddr_a (mem_raddr_a),
      .rdata_a (mem_rdata_a),
      .re_b    (mem_re_b),
      .raddr_b (mem_raddr_b),
      .rdata_b (mem_rdata_b)
   );

   assign rsp_done_res = 1'b1;

   `ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(a_reach_finite, clock, reset, rsp_valid && rsp_reachable, rsp_distance != DIST_INF)
   `ASSERT_IMPLIES(a_unreach_code, clock, reset, rsp_valid && !rsp_reachable, rsp_distance == '0 || rsp_distance == DIST_INF)

endmodule
`default_nettype wire

### sim/tb_all_pairs_shortest_path.sv
module tb_all_pairs_shortest_path;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXV = apsp_pkg::MAX_VERTICES_DEF;
   localparam int CW = apsp_pkg::COST_WIDTH_DEF;
   localparam int DW = apsp_pkg::DIST_WIDTH_DEF;
   localparam int VCW = apsp_pkg::VCOUNT_WIDTH;
   localparam int VXW = apsp_pkg::VERTEX_WIDTH;
   localparam logic [DW-1:0] DIST_INF = '1;
   localparam int HOLD_CYCLES = 5000;
   localparam int ITEMS_PER_PHASE = 40;

   typedef struct packed {
      logic [DW-1:0] distance;
      logic reachable;
      logic done_res;
   } answer_type;

   typedef struct packed {
      logic is_cfg;
      logic [VCW-1:0] cfg_value;
      apsp_pkg::cmd_type cmd;
      logic [VXW-1:0] from_v;
      logic [VXW-1:0] to_v;
      logic [CW-1:0] cost;
      logic typed;
      logic [DW-1:0] exp_dist;
      logic exp_reach;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VCW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [apsp_pkg::CMD_WIDTH-1:0] req_command = apsp_pkg::CMD_CLEAR;
   logic [VXW-1:0] req_from_vertex = '0;
   logic [VXW-1:0] req_to_vertex = '0;
   logic [CW-1:0] req_edge_cost = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DW-1:0] rsp_distance;
   logic rsp_reachable;
   logic rsp_done_res;

   logic [DW-1:0] dist_grid [MAXV][MAXV];
   logic [VCW-1:0] vcount_shadow;
   answer_type pending_answers [$];
   int mismatches = 0;
   int send_idle = 11;
   int recv_idle = 79;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   // Columns: is_cfg, cfg_value, cmd, from, to, cost, typed, distance, reachable.
   stim_row_type directed_rows [0:28] = '{
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd0, 6'd0, 16'd0, 1'b1, 24'd0, 1'b1},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd0, 6'd63, 16'd0, 1'b1, DIST_INF, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd63, 6'd63, 16'd0, 1'b1, 24'd0, 1'b1},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd0, 6'd63, 16'hFFFF, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd63, 6'd0, 16'd0, 1'b1, 24'h00FFFF, 1'b1},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd5, 6'd5, 16'd7, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd5, 6'd5, 16'd0, 1'b1, 24'd7, 1'b1},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd1, 6'd2, 16'd0, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd2, 6'd63, 16'hFFFF, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd1, 6'd0, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd62, 6'd61, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_CLEAR, 6'd63, 6'd63, 16'hFFFF, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd63, 6'd0, 16'd0, 1'b1, DIST_INF, 1'b0},
      '{1'b1, 7'd0, apsp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd0, 6'd1, 16'd5, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd0, 6'd0, 16'd0, 1'b1, DIST_INF, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0, 1'b1, 24'd0, 1'b0},
      '{1'b1, 7'd127, apsp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd63, 6'd62, 16'd3, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd62, 6'd63, 16'd0, 1'b1, 24'd3, 1'b1},
      '{1'b1, 7'd4, apsp_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd0, 6'd1, 16'd10, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd1, 6'd2, 16'd20, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd2, 6'd3, 16'hFFFF, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_EDGE, 6'd0, 6'd4, 16'd1, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_SOLVE, 6'd0, 6'd0, 16'd0, 1'b1, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd0, 6'd3, 16'd0, 1'b0, 24'd0, 1'b0},
      '{1'b0, 7'd0, apsp_pkg::CMD_QUERY, 6'd0, 6'd4, 16'd0, 1'b1, DIST_INF, 1'b0}
   };

   int phase_counts [9] = '{1, 8, 64, 3, 127, 6, 2, 5, 7};

   all_pairs_shortest_path DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .req_edge_cost(req_edge_cost),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_reachable(rsp_reachable),
      .rsp_done_res(rsp_done_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void wipe_grid();
      for (int r = 0; r < MAXV; r++) begin
         for (int col = 0; col < MAXV; col++) begin
            dist_grid[r][col] = (r == col) ? '0 : DIST_INF;
         end
      end
   endfunction

   function automatic logic [DW-1:0] add_saturating(input logic [DW-1:0] x,
                                                    input logic [DW-1:0] y);
      logic [DW:0] total;
      if (x == DIST_INF || y == DIST_INF) begin
         return DIST_INF;
      end
      total = x + y;
      return (total >= DIST_INF) ? DIST_INF : total[DW-1:0];
   endfunction

   function automatic answer_type predict_distance(input apsp_pkg::cmd_type c,
                                                   input logic [VXW-1:0] a,
                                                   input logic [VXW-1:0] b,
                                                   input logic [CW-1:0] cost);
      answer_type ans;
      int n;
      logic [DW-1:0] alt;
      ans = '{distance: '0, reachable: 1'b0, done_res: 1'b1};
      n = (vcount_shadow > MAXV) ? MAXV : int'(vcount_shadow);
      case (c)
         apsp_pkg::CMD_CLEAR: begin
            wipe_grid();
         end
         apsp_pkg::CMD_EDGE: begin
            if (a < n && b < n) begin
               dist_grid[a][b] = DW'(cost);
               dist_grid[b][a] = DW'(cost);
            end
         end
         apsp_pkg::CMD_SOLVE: begin
            for (int via = 0; via < n; via++) begin
               for (int src = 0; src < n; src++) begin
                  for (int dst = 0; dst < n; dst++) begin
                     alt = add_saturating(dist_grid[src][via], dist_grid[via][dst]);
                     if (alt < dist_grid[src][dst]) begin
                        dist_grid[src][dst] = alt;
                     end
                  end
               end
            end
         end
         default: begin
            ans.distance = (a < n && b < n) ? dist_grid[a][b] : DIST_INF;
            ans.reachable = (ans.distance != DIST_INF);
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns mismatch: %s", $time, what);
      end
   endtask

   task automatic send_word(input apsp_pkg::cmd_type c, input logic [VXW-1:0] a,
                            input logic [VXW-1:0] b, input logic [CW-1:0] cost,
                            input bit typed = 1'b0, input answer_type typed_ans = '0);
      answer_type predicted;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_from_vertex <= a;
      req_to_vertex <= b;
      req_edge_cost <= cost;
      do @(posedge clock); while (!req_ready);
      predicted = predict_distance(c, a, b, cost);
      pending_answers.insert(pending_answers.size(), typed ? typed_ans : predicted);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_answers.size() != 0);
      @(posedge clock);
   endtask

   task automatic set_vertex_count(input logic [VCW-1:0] value);
      wait_for_answers();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vcount_shadow = value;
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_armed && !hold_done && rsp_valid && rsp_ready) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("result word arrived with nothing expected");
         end else begin
            want = pending_answers.pop_front();
            if (rsp_distance !== want.distance) begin
               report_mismatch($sformatf("distance %0h, expected %0h",
                                         rsp_distance, want.distance));
            end
            if (rsp_reachable !== want.reachable) begin
               report_mismatch($sformatf("reachable %b, expected %b",
                                         rsp_reachable, want.reachable));
            end
            if (rsp_done_res !== want.done_res) begin
               report_mismatch($sformatf("done_res %b, expected %b",
                                         rsp_done_res, want.done_res));
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      apsp_pkg::cmd_type c;
      int ne;
      int sent;
      int edges;
      bit big;
      vcount_shadow = apsp_pkg::VCOUNT_RESET;
      wipe_grid();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            set_vertex_count(row.cfg_value);
         end else begin
            send_word(row.cmd, row.from_v, row.to_v, row.cost, row.typed,
                      '{distance: row.exp_dist, reachable: row.exp_reach, done_res: 1'b1});
         end
      end

      for (int p = 0; p < 9; p++) begin
         set_vertex_count(VCW'(phase_counts[p]));
         send_idle = (p < 3) ? 11 : (p < 6) ? 79 : 0;
         recv_idle <= (p < 3) ? 79 : (p < 6) ? 11 : 0;
         if (p == 7) begin
            hold_armed <= 1'b1;
         end
         ne = (phase_counts[p] > MAXV) ? MAXV : phase_counts[p];
         big = (ne > 16);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(7) == 0) begin
               c = apsp_pkg::cmd_type'($urandom_range(1, 3));
               if (big && c == apsp_pkg::CMD_SOLVE) begin
                  c = apsp_pkg::CMD_QUERY;
               end
               send_word(c, 6'($urandom), 6'($urandom), 16'($urandom));
               sent++;
            end else begin
               if ($urandom_range(3) == 0) begin
                  send_word(apsp_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom),
                            16'($urandom));
                  sent++;
               end
               edges = $urandom_range(1, (ne < 6) ? 2 * ne : 12);
               repeat (edges) begin
                  send_word(apsp_pkg::CMD_EDGE, 6'($urandom_range(ne - 1)),
                            6'($urandom_range(ne - 1)),
                            ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
                  sent++;
               end
               if (!big) begin
                  send_word(apsp_pkg::CMD_SOLVE, 6'($urandom), 6'($urandom),
                            16'($urandom));
                  sent++;
               end
               repeat ($urandom_range(1, 6)) begin
                  send_word(apsp_pkg::CMD_QUERY, 6'($urandom_range(ne - 1)),
                            6'($urandom_range(ne - 1)), 16'($urandom));
                  sent++;
               end
            end
         end
      end

      wait_for_answers();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
